// ===== design/ddpe_pkg.sv =====
// shared types and constants for the differential drive pwm encoder
// used by ddpe_ctrl, ddpe_dp and diff_drive_pwm_encoder; no dependencies
package ddpe_pkg;

    // 45 degrees in 1/256 degree units
    localparam logic [13:0] HALF_QUARTER = 14'd11520;
    // full-scale duty magnitude
    localparam logic [5:0]  FULL_DUTY    = 6'd63;
    // reset value of the full-scale boost speed
    localparam logic [14:0] NITRO_RESET  = 15'd1000;
    // last index of the six quotient-bit division steps
    localparam logic [2:0]  LAST_STEP    = 3'd5;

    // side select
    localparam logic SIDE_LEFT  = 1'b0;
    localparam logic SIDE_RIGHT = 1'b1;

    // controller states, one-hot
    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_MUL   = 8'b0000_0010,
        ST_PREP  = 8'b0000_0100,
        ST_DIV   = 8'b0000_1000,
        ST_STORE = 8'b0001_0000,
        ST_CHK   = 8'b0010_0000,
        ST_OUT_L = 8'b0100_0000,
        ST_OUT_R = 8'b1000_0000
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic side;
        logic mul;
        logic prep;
        logic step;
        logic store;
        logic emit_l;
        logic emit_r;
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic l_chg;
        logic r_chg;
    } t_dp_stat;

endpackage

// ===== design/ddpe_dp.sv =====
// datapath: input capture, wheel mixing multiply, serial restoring divider,
// duty history and output register; depends on ddpe_pkg
module ddpe_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [14:0]         i_cfg_wdata,
    input  logic [15:0]         i_speed,
    input  logic [15:0]         i_steer_angle,
    input  logic                i_boost_left,
    input  logic                i_boost_right,
    input  ddpe_pkg::t_dp_cmd   i_cmd,
    output ddpe_pkg::t_dp_stat  o_stat,
    output logic [7:0]          o_command_byte,
    output logic                o_last_byte
);

    logic [14:0]        r_nitro;
    logic [15:0]        r_spd;
    logic [15:0]        r_ang;
    logic               r_bl;
    logic               r_br;
    logic [28:0]        r_dv;
    logic signed [32:0] r_num;
    logic [38:0]        r_rem;
    logic [38:0]        r_dsh;
    logic [5:0]         r_q;
    logic               r_fixed;
    logic               r_neg;
    logic [7:0]         r_ld;
    logic [7:0]         r_rd;
    logic [7:0]         r_prev_l;
    logic [7:0]         r_prev_r;
    logic [7:0]         r_out;
    logic               r_last;

    logic [14:0]        w_div;
    logic [28:0]        w_dv;
    logic signed [16:0] w_k;
    logic signed [16:0] w_ang;
    logic signed [16:0] w_fac;
    logic signed [32:0] w_spd33;
    logic signed [32:0] w_fac33;
    logic [32:0]        w_mag;
    logic [38:0]        w_n;
    logic [38:0]        w_d6;
    logic [38:0]        w_d5;
    logic               w_boost;
    logic [7:0]         w_duty;

    // divisor: 45 degrees times full-scale speed, zero treated as one
    assign w_div = (r_nitro == 15'd0) ? 15'd1 : r_nitro;
    assign w_dv  = {15'd0, ddpe_pkg::HALF_QUARTER} * {14'd0, w_div};

    // steering factor for the selected side
    assign w_k   = {3'b000, ddpe_pkg::HALF_QUARTER};
    assign w_ang = {r_ang[15], r_ang};
    always_comb begin
        if (i_cmd.side == ddpe_pkg::SIDE_LEFT) begin
            w_fac = r_ang[15] ? w_k : (w_k - w_ang);
        end else begin
            w_fac = r_ang[15] ? (w_k + w_ang) : w_k;
        end
    end
    assign w_spd33 = {{17{r_spd[15]}}, r_spd};
    assign w_fac33 = {{16{w_fac[16]}}, w_fac};

    // magnitude times 63 and shifted divisors
    assign w_mag   = r_num[32] ? 33'(-r_num) : 33'(r_num);
    assign w_n     = {w_mag, 6'd0} - {6'd0, w_mag};
    assign w_d6    = {4'd0, r_dv, 6'd0};
    assign w_d5    = {5'd0, r_dv, 5'd0};
    assign w_boost = (i_cmd.side == ddpe_pkg::SIDE_LEFT) ? r_bl : r_br;

    // signed duty from magnitude
    assign w_duty = r_neg ? 8'(-{2'b00, r_q}) : {2'b00, r_q};

    // configuration register and duty history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nitro  <= ddpe_pkg::NITRO_RESET;
            r_prev_l <= 8'd0;
            r_prev_r <= 8'd0;
        end else begin
            if (i_cfg_we) begin
                r_nitro <= i_cfg_wdata;
            end
            if (i_cmd.emit_l) begin
                r_prev_l <= r_ld;
            end
            if (i_cmd.emit_r) begin
                r_prev_r <= r_rd;
            end
        end
    end

    // input capture and wheel product
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_spd <= i_speed;
            r_ang <= i_steer_angle;
            r_bl  <= i_boost_left;
            r_br  <= i_boost_right;
            r_dv  <= w_dv;
        end
        if (i_cmd.mul) begin
            r_num <= w_spd33 * w_fac33;
        end
    end

    // division setup, one quotient bit per step
    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_neg <= r_num[32];
            r_rem <= w_n;
            r_dsh <= w_d5;
            if (r_num == 33'sd0) begin
                r_q     <= 6'd0;
                r_fixed <= 1'b1;
            end else if (w_boost || (w_n >= w_d6)) begin
                r_q     <= ddpe_pkg::FULL_DUTY;
                r_fixed <= 1'b1;
            end else begin
                r_q     <= 6'd0;
                r_fixed <= 1'b0;
            end
        end else if (i_cmd.step && !r_fixed) begin
            if (r_rem >= r_dsh) begin
                r_rem <= r_rem - r_dsh;
                r_q   <= {r_q[4:0], 1'b1};
            end else begin
                r_q   <= {r_q[4:0], 1'b0};
            end
            r_dsh <= {1'b0, r_dsh[38:1]};
        end
    end

    // per-side duty
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            if (i_cmd.side == ddpe_pkg::SIDE_LEFT) begin
                r_ld <= w_duty;
            end else begin
                r_rd <= w_duty;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_l) begin
            r_out  <= {1'b0, r_ld[6:0]};
            r_last <= !o_stat.r_chg;
        end else if (i_cmd.emit_r) begin
            r_out  <= {1'b1, r_rd[6:0]};
            r_last <= 1'b1;
        end
    end

    assign o_stat.l_chg   = (r_ld != r_prev_l);
    assign o_stat.r_chg   = (r_rd != r_prev_r);
    assign o_command_byte = r_out;
    assign o_last_byte    = r_last;

endmodule

// ===== design/ddpe_ctrl.sv =====
// controller: sequences multiply, divide and emit steps for both wheels
// and drives the stream handshakes; depends on ddpe_pkg
module ddpe_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  ddpe_pkg::t_dp_stat  i_stat,
    output ddpe_pkg::t_dp_cmd   o_cmd
);

    ddpe_pkg::t_state r_state;
    ddpe_pkg::t_state n_state;
    logic             r_side;
    logic             n_side;
    logic [2:0]       r_cnt;
    logic [2:0]       n_cnt;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_side  = r_side;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.side = r_side;
        case (r_state)
            ddpe_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_side     = ddpe_pkg::SIDE_LEFT;
                    n_state    = ddpe_pkg::ST_MUL;
                end
            end
            ddpe_pkg::ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ddpe_pkg::ST_PREP;
            end
            ddpe_pkg::ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_cnt      = 3'd0;
                n_state    = ddpe_pkg::ST_DIV;
            end
            ddpe_pkg::ST_DIV: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt + 3'd1;
                if (r_cnt == ddpe_pkg::LAST_STEP) begin
                    n_state = ddpe_pkg::ST_STORE;
                end
            end
            ddpe_pkg::ST_STORE: begin
                o_cmd.store = 1'b1;
                if (r_side == ddpe_pkg::SIDE_LEFT) begin
                    n_side  = ddpe_pkg::SIDE_RIGHT;
                    n_state = ddpe_pkg::ST_MUL;
                end else begin
                    n_state = ddpe_pkg::ST_CHK;
                end
            end
            ddpe_pkg::ST_CHK: begin
                if (i_stat.l_chg) begin
                    o_cmd.emit_l = 1'b1;
                    n_state      = ddpe_pkg::ST_OUT_L;
                end else if (i_stat.r_chg) begin
                    o_cmd.emit_r = 1'b1;
                    n_state      = ddpe_pkg::ST_OUT_R;
                end else begin
                    n_state = ddpe_pkg::ST_IDLE;
                end
            end
            ddpe_pkg::ST_OUT_L: begin
                if (i_out_ready) begin
                    if (i_stat.r_chg) begin
                        o_cmd.emit_r = 1'b1;
                        n_state      = ddpe_pkg::ST_OUT_R;
                    end else begin
                        n_state = ddpe_pkg::ST_IDLE;
                    end
                end
            end
            ddpe_pkg::ST_OUT_R: begin
                if (i_out_ready) begin
                    n_state = ddpe_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ddpe_pkg::ST_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ddpe_pkg::ST_IDLE;
            r_side  <= ddpe_pkg::SIDE_LEFT;
            r_cnt   <= 3'd0;
        end else begin
            r_state <= n_state;
            r_side  <= n_side;
            r_cnt   <= n_cnt;
        end
    end

    assign o_in_ready  = (r_state == ddpe_pkg::ST_IDLE);
    assign o_out_valid = (r_state == ddpe_pkg::ST_OUT_L) || (r_state == ddpe_pkg::ST_OUT_R);

endmodule

// ===== design/diff_drive_pwm_encoder.sv =====
// differential drive mixer and command byte encoder, top level
// each wheel in turn takes a multiply, a setup, six divider steps and a store,
// then a check state picks the command bytes to send
// no new request is taken until every command byte of the last one is sent
// reset: synchronous active low; nitro speed returns to 1000, duty history to 0
// depends on ddpe_pkg, ddpe_ctrl and ddpe_dp
module diff_drive_pwm_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [14:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] speed, [31:16] steer_angle
    input  logic [1:0]  s_axis_tuser,   // [0] boost_left, [1] boost_right
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] command_byte
    output logic        m_axis_tlast
);

    ddpe_pkg::t_dp_cmd  w_cmd;
    ddpe_pkg::t_dp_stat w_stat;

    // sequencer
    ddpe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // arithmetic and storage
    ddpe_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_speed        (s_axis_tdata[15:0]),
        .i_steer_angle  (s_axis_tdata[31:16]),
        .i_boost_left   (s_axis_tuser[0]),
        .i_boost_right  (s_axis_tuser[1]),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .o_command_byte (m_axis_tdata),
        .o_last_byte    (m_axis_tlast)
    );

endmodule

// ===== sim/tb_diff_drive_pwm_encoder.sv =====
// testbench for diff_drive_pwm_encoder: directed and random joystick requests
// checked byte by byte against a wheel duty predictor; needs ddpe_pkg and the rtl

// tracks nitro speed and per-side duty history, predicts the command bytes
class wheel_cmd_scoreboard;
    logic [14:0] nitro;
    logic [7:0]  left_duty;
    logic [7:0]  right_duty;
    logic [8:0]  bytes_due[$];  // {last, command byte}
    int          errors;

    function new();
        nitro      = ddpe_pkg::NITRO_RESET;
        left_duty  = 8'd0;
        right_duty = 8'd0;
        errors     = 0;
    endfunction

    // num is the wheel value times 45 degrees
    function logic [7:0] duty_for(longint num, bit boost);
        longint div;
        longint mag;
        longint q;
        longint k;
        longint full;
        k    = longint'(ddpe_pkg::HALF_QUARTER);
        full = longint'(ddpe_pkg::FULL_DUTY);
        // zero divisor is treated as one
        div  = (nitro == 15'd0) ? 64'sd1 : longint'(nitro);
        if (num == 0) return 8'd0;
        mag = (num < 0) ? -num : num;
        if (boost) begin
            q = full;
        end else begin
            q = (mag * full) / (k * div);
            if (q > full) q = full;
        end
        return (num < 0) ? 8'(-q) : 8'(q);
    endfunction

    function void note_request(logic [15:0] spd, logic [15:0] ang, bit bl, bit br);
        longint s;
        longint a;
        longint k;
        longint lnum;
        longint rnum;
        logic [7:0] ld;
        logic [7:0] rd;
        bit lchg;
        bit rchg;
        s = longint'($signed(spd));
        a = longint'($signed(ang));
        k = longint'(ddpe_pkg::HALF_QUARTER);
        // the wheel on the inside of the turn slows down
        if (a >= 0) begin
            rnum = s * k;
            lnum = s * (k - a);
        end else begin
            lnum = s * k;
            rnum = s * (k + a);
        end
        ld   = duty_for(lnum, bl);
        rd   = duty_for(rnum, br);
        lchg = (ld != left_duty);
        rchg = (rd != right_duty);
        // only changed sides are sent, left first
        if (lchg) begin
            bytes_due.push_back({!rchg, ddpe_pkg::SIDE_LEFT, ld[6:0]});
            left_duty = ld;
        end
        if (rchg) begin
            bytes_due.push_back({1'b1, ddpe_pkg::SIDE_RIGHT, rd[6:0]});
            right_duty = rd;
        end
    endfunction

    function void flag(string msg);
        errors++;
        if (errors <= 10) $display("mismatch: %s", msg);
    endfunction

    function void check_byte(logic [7:0] data, logic last);
        logic [8:0] want;
        if (bytes_due.size() == 0) begin
            flag($sformatf("byte %02h last %0b with nothing outstanding", data, last));
            return;
        end
        want = bytes_due.pop_front();
        if (want[7:0] !== data)
            flag($sformatf("command_byte expected %02h, got %02h", want[7:0], data));
        if (want[8] !== last)
            flag($sformatf("last_byte expected %0b, got %0b (byte %02h)", want[8], last, data));
    endfunction
endclass

module tb_diff_drive_pwm_encoder;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 60;
    localparam int HOLD_CYCLES   = 400;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [14:0] i_cfg_wdata   = 15'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = 32'd0;   // [15:0] speed, [31:16] steer_angle
    logic [1:0]  s_axis_tuser  = 2'd0;    // [0] boost_left, [1] boost_right
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;            // [7:0] command_byte
    logic        m_axis_tlast;

    wheel_cmd_scoreboard sb;
    int tx_gap_pct   = 0;
    int rx_stall_pct = 0;
    bit hold_req     = 1'b0;
    int cycle_count  = 0;

    diff_drive_pwm_encoder u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // check bytes before noting the request taken on the same edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_byte(m_axis_tdata, m_axis_tlast);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_request(s_axis_tdata[15:0], s_axis_tdata[31:16],
                                s_axis_tuser[0], s_axis_tuser[1]);
        end
    end

    // output side: random stall bursts and one long hold-off on request
    initial begin : receiver
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
                m_axis_tready <= 1'b1;
            end else if ($urandom_range(0, 99) < rx_stall_pct) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // one request, with an optional idle burst ahead of it
    task automatic send_request(input logic [15:0] spd, input logic [15:0] ang,
                                input bit bl, input bit br);
        if ($urandom_range(0, 99) < tx_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ang, spd};
        s_axis_tuser  <= {br, bl};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // wait for every byte, then let a request with no bytes finish
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.bytes_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_nitro(input logic [14:0] v);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.nitro     = v;
    endtask

    // speeds mostly within a quarter past full scale so duties spread over all steps
    task automatic send_random(input int count);
        int lim;
        int spd;
        int ang;
        int sel;
        bit bl;
        bit br;
        for (int i = 0; i < count; i++) begin
            lim = (sb.nitro > 15'd26000) ? 32767 : int'(sb.nitro) + int'(sb.nitro) / 4 + 2;
            if ($urandom_range(0, 9) == 0)
                spd = int'($urandom_range(0, 65535)) - 32768;
            else
                spd = int'($urandom_range(0, 2 * lim)) - lim;
            sel = $urandom_range(0, 9);
            case (sel)
                0: begin
                    ang = 0;
                end
                1: begin
                    ang = int'(ddpe_pkg::HALF_QUARTER);
                end
                2: begin
                    ang = -int'(ddpe_pkg::HALF_QUARTER);
                end
                3: begin
                    ang = 2 * int'(ddpe_pkg::HALF_QUARTER);
                end
                4: begin
                    ang = -2 * int'(ddpe_pkg::HALF_QUARTER);
                end
                default: begin
                    ang = int'($urandom_range(0, 46080)) - 23040;
                end
            endcase
            bl = ($urandom_range(0, 3) == 0);
            br = ($urandom_range(0, 3) == 0);
            send_request(16'(spd), 16'(ang), bl, br);
        end
    endtask

    task automatic run_phase(input logic [14:0] v, input int count,
                             input int tx_pct, input int rx_pct);
        write_nitro(v);
        tx_gap_pct   = tx_pct;
        rx_stall_pct = rx_pct;
        send_random(count);
    endtask

    initial begin : stimulus
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset nitro speed
        send_request(16'd0, 16'd0, 1'b0, 1'b0);          // zero with zero history
        send_request(16'd1000, 16'd0, 1'b0, 1'b0);       // both full forward
        send_request(16'h7fff, 16'd0, 1'b0, 1'b0);       // saturated, no change
        send_request(16'h8000, 16'd0, 1'b0, 1'b0);       // most negative speed
        send_request(16'd500, 16'd11520, 1'b0, 1'b0);    // pivot on the left wheel
        send_request(16'd500, -16'sd11520, 1'b0, 1'b0);  // pivot on the right wheel
        send_request(16'd1000, 16'd23040, 1'b0, 1'b0);   // angle past 45 degrees
        send_request(16'd1000, -16'sd23040, 1'b0, 1'b0);
        send_request(-16'sd1000, 16'd23040, 1'b0, 1'b0); // same duties, no bytes
        send_request(16'd1, 16'd0, 1'b1, 1'b1);          // boost forward
        send_request(-16'sd1, 16'd0, 1'b1, 1'b1);        // boost reverse
        send_request(16'd0, 16'd7000, 1'b1, 1'b1);       // boost keeps zero at zero
        send_request(16'd1, 16'd5000, 1'b0, 1'b0);       // truncates to zero
        send_request(16'h7fff, 16'd23040, 1'b1, 1'b0);   // boost on a reversed wheel
        send_request(16'h8000, -16'sd23040, 1'b0, 1'b1);
        send_request(16'h7fff, 16'hffff, 1'b0, 1'b0);    // angle just below zero

        // directed: smallest divisor
        write_nitro(15'd1);
        send_request(16'd1, 16'd0, 1'b0, 1'b0);
        send_request(16'd1, 16'd11519, 1'b0, 1'b0);
        send_request(-16'sd1, -16'sd11519, 1'b0, 1'b0);

        // directed: largest divisor
        write_nitro(15'h7fff);
        send_request(16'h7fff, 16'd0, 1'b0, 1'b0);
        send_request(16'h7ffe, 16'd0, 1'b0, 1'b0);
        send_request(16'h8000, 16'd0, 1'b0, 1'b0);
        send_request(16'd520, 16'd0, 1'b0, 1'b0);

        // directed: zero divisor acts as one
        write_nitro(15'd0);
        send_request(16'd1, 16'd0, 1'b0, 1'b0);
        send_request(16'd0, 16'd0, 1'b0, 1'b0);

        // random phases over several nitro speeds
        run_phase(ddpe_pkg::NITRO_RESET, 90, 20, 20);
        // output held off while requests keep coming
        hold_req   = 1'b1;
        tx_gap_pct = 0;
        send_random(30);
        tx_gap_pct = 20;
        run_phase(15'($urandom_range(1, 32767)), 110, 10, 25);
        run_phase(15'd1, 80, 30, 10);
        run_phase(15'h7fff, 100, 0, 30);
        run_phase(15'($urandom_range(20, 300)), 100, 25, 0);
        run_phase(15'd0, 30, 15, 15);
        // last stretch with no idling on either side
        run_phase(15'($urandom_range(500, 5000)), 100, 0, 0);

        wait_drained();
        if (sb.errors == 0 && sb.bytes_due.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== diff_drive_pwm_encoder.f =====
design/ddpe_pkg.sv
design/ddpe_dp.sv
design/ddpe_ctrl.sv
design/diff_drive_pwm_encoder.sv
sim/tb_diff_drive_pwm_encoder.sv
